### rtl/core/clas_pkg.sv
package clas_pkg;

  localparam int BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t CH_NUL       = 8'h00;
  localparam byte_t CH_TAB       = 8'h09;
  localparam byte_t CH_SPACE     = 8'h20;
  localparam byte_t CH_QUOTE     = 8'h22;
  localparam byte_t CH_BACKSLASH = 8'h5C;

  // third quote in a run gives a literal quote
  localparam logic [1:0] QUOTE_RUN_LIT = 2'd3;
  localparam logic [1:0] QUOTE_PAIR    = 2'd2;

endpackage

### rtl/core/command_line_argument_splitter_top.sv
// A result word is registered on the output in the cycle after its byte is accepted.
// Throughput: one line byte per cycle; a byte is taken whenever the output register is empty
// or is being drained in the same cycle, so a stalled result only holds off the input.
// Bytes that give no result (backslashes, opening quotes, blanks between arguments) are still
// consumed as input. Reset (rst, synchronous) returns the splitter to the start of a line,
// empties the output register and clears all counts; each line end also restarts and clears.
module command_line_argument_splitter_top #(
  parameter int MAX_ARGS          = 255,
  parameter int MAX_BACKSLASH_RUN = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  clas_pkg::byte_t      line_byte,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output clas_pkg::byte_t      backslash_run,
  output clas_pkg::byte_t      out_byte,
  output logic                 byte_valid,
  output logic                 arg_end,
  output logic                 line_end,
  output clas_pkg::byte_t      arg_total,
  output logic                 empty_line
);

  // Widths of the running counts follow their saturation limits.
  localparam int BsW  = $clog2(MAX_BACKSLASH_RUN + 1);
  localparam int ArgW = $clog2(MAX_ARGS + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_FIRST_PLAIN,
    PH_FIRST_QUOTED,
    PH_BETWEEN,
    PH_ARG
  } phase_t;

  // Running state of the splitter
  phase_t          phase, phase_next;
  logic [BsW-1:0]  bs_count, bs_count_next;     // pending backslashes
  logic [1:0]      quote_count, quote_count_next;
  logic            in_quote_run, in_quote_run_next;
  logic [ArgW-1:0] args_seen, args_seen_next;

  // Result of the byte being accepted
  logic            emit;
  logic [BsW-1:0]  r_bs;
  clas_pkg::byte_t r_byte;
  logic            r_valid;
  logic            r_aend;
  logic            r_lend;
  logic [ArgW-1:0] r_total;
  logic            r_empty;

  // Later-argument view of the state: cleared when a new argument opens
  logic [BsW-1:0]  a_bs;
  logic [1:0]      a_qc;
  logic            a_run;
  logic [1:0]      qc_inc;
  logic [1:0]      qc_after;
  logic            is_blank;

  logic            accept;

  // Output register; it parts the two sides, so the input only waits on a held word.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_blank = line_byte inside {clas_pkg::CH_SPACE, clas_pkg::CH_TAB};

    phase_next        = phase;
    bs_count_next     = bs_count;
    quote_count_next  = quote_count;
    in_quote_run_next = in_quote_run;
    args_seen_next    = args_seen;

    emit    = 1'b0;
    r_bs    = '0;
    r_byte  = clas_pkg::CH_NUL;
    r_valid = 1'b0;
    r_aend  = 1'b0;
    r_lend  = 1'b0;
    r_total = '0;
    r_empty = 1'b0;

    // a new later argument starts from cleared backslash and quote state
    if (phase == PH_BETWEEN) begin
      a_bs  = '0;
      a_qc  = '0;
      a_run = 1'b0;
    end else begin
      a_bs  = bs_count;
      a_qc  = quote_count;
      a_run = in_quote_run;
    end
    qc_inc   = a_qc + 2'd1;
    // leaving a quote run: a pair of quotes closes the quoted section
    qc_after = (a_run && a_qc == clas_pkg::QUOTE_PAIR) ? 2'd0 : a_qc;

    case (phase)
      PH_START: begin
        if (line_byte == clas_pkg::CH_NUL) begin
          emit    = 1'b1;
          r_lend  = 1'b1;
          r_empty = 1'b1;
        end else begin
          args_seen_next = ArgW'(1);
          if (line_byte == clas_pkg::CH_QUOTE) begin
            phase_next = PH_FIRST_QUOTED;
          end else if (is_blank) begin
            phase_next = PH_BETWEEN;
            emit       = 1'b1;
            r_aend     = 1'b1;
          end else begin
            phase_next = PH_FIRST_PLAIN;
            emit       = 1'b1;
            r_byte     = line_byte;
            r_valid    = 1'b1;
          end
        end
      end

      PH_FIRST_PLAIN, PH_FIRST_QUOTED: begin
        emit = 1'b1;
        if (line_byte == clas_pkg::CH_NUL) begin
          r_aend  = 1'b1;
          r_lend  = 1'b1;
          r_total = args_seen;
        end else if ((phase == PH_FIRST_PLAIN && is_blank) ||
                     (phase == PH_FIRST_QUOTED && line_byte == clas_pkg::CH_QUOTE)) begin
          phase_next = PH_BETWEEN;
          r_aend     = 1'b1;
        end else begin
          r_byte  = line_byte;
          r_valid = 1'b1;
        end
      end

      PH_BETWEEN, PH_ARG: begin
        if (phase == PH_BETWEEN && line_byte == clas_pkg::CH_NUL) begin
          emit    = 1'b1;
          r_lend  = 1'b1;
          r_total = args_seen;
        end else if (phase == PH_BETWEEN && is_blank) begin
          emit = 1'b0;
        end else begin
          if (phase == PH_BETWEEN) begin
            phase_next = PH_ARG;
            if (args_seen < ArgW'(MAX_ARGS)) begin
              args_seen_next = args_seen + ArgW'(1);
            end
          end
          bs_count_next     = a_bs;
          quote_count_next  = a_qc;
          in_quote_run_next = a_run;

          if (line_byte == clas_pkg::CH_QUOTE) begin
            if (a_run) begin
              if (qc_inc == clas_pkg::QUOTE_RUN_LIT) begin
                quote_count_next = 2'd0;
                emit             = 1'b1;
                r_byte           = clas_pkg::CH_QUOTE;
                r_valid          = 1'b1;
              end else begin
                quote_count_next = qc_inc;
              end
            end else begin
              // backslashes before a quote are halved; an odd run escapes the quote
              in_quote_run_next = 1'b1;
              bs_count_next     = '0;
              r_bs              = a_bs >> 1;
              if (!a_bs[0]) begin
                quote_count_next = qc_inc;
                emit             = (r_bs != '0);
              end else begin
                emit    = 1'b1;
                r_byte  = clas_pkg::CH_QUOTE;
                r_valid = 1'b1;
              end
            end
          end else begin
            in_quote_run_next = 1'b0;
            quote_count_next  = qc_after;
            if (line_byte == clas_pkg::CH_NUL) begin
              emit    = 1'b1;
              r_bs    = a_bs;
              r_aend  = 1'b1;
              r_lend  = 1'b1;
              r_total = args_seen_next;
            end else if (is_blank && qc_after == 2'd0) begin
              bs_count_next = '0;
              phase_next    = PH_BETWEEN;
              emit          = 1'b1;
              r_bs          = a_bs;
              r_aend        = 1'b1;
            end else if (line_byte == clas_pkg::CH_BACKSLASH) begin
              if (a_bs < BsW'(MAX_BACKSLASH_RUN)) begin
                bs_count_next = a_bs + BsW'(1);
              end
            end else begin
              bs_count_next = '0;
              emit          = 1'b1;
              r_bs          = a_bs;
              r_byte        = line_byte;
              r_valid       = 1'b1;
            end
          end
        end
      end

      default: begin
        phase_next = PH_START;
      end
    endcase

    // every line end, and any stray phase code, starts a fresh line
    if (r_lend || phase_next == PH_START) begin
      phase_next        = PH_START;
      bs_count_next     = '0;
      quote_count_next  = '0;
      in_quote_run_next = 1'b0;
      args_seen_next    = '0;
    end
  end

  // Result fields are reported modulo 256.
  logic [31:0] bs_wide;
  logic [31:0] total_wide;
  assign bs_wide    = 32'(r_bs);
  assign total_wide = 32'(r_total);

  // state and result word; the payload is loaded only when a word is produced
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      bs_count     <= '0;
      quote_count  <= '0;
      in_quote_run <= 1'b0;
      args_seen    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        bs_count     <= bs_count_next;
        quote_count  <= quote_count_next;
        in_quote_run <= in_quote_run_next;
        args_seen    <= args_seen_next;
      end
      if (accept && emit) begin
        out_valid     <= 1'b1;
        backslash_run <= bs_wide[7:0];
        out_byte      <= r_byte;
        byte_valid    <= r_valid;
        arg_end       <= r_aend;
        line_end      <= r_lend;
        arg_total     <= total_wide[7:0];
        empty_line    <= r_empty;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // At the start of a line nothing is carried over from the previous one.
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> (args_seen == '0 && bs_count == '0 && quote_count == 2'd0
                           && !in_quote_run))
    else $error("state not cleared at start of line");

  // Backslash runs only build up inside later arguments.
  a_first_no_bs: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FIRST_PLAIN || phase == PH_FIRST_QUOTED || phase == PH_BETWEEN)
      |-> bs_count == '0)
    else $error("pending backslashes outside a later argument");

  // A third quote always folds back to zero.
  a_qc_range: assert property (@(posedge clk) disable iff (rst)
    quote_count != clas_pkg::QUOTE_RUN_LIT)
    else $error("quote count reached three");

  // An empty line reports no arguments and no character.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_line |-> (line_end && arg_total == '0 && !byte_valid && !arg_end))
    else $error("malformed empty-line word");

  // A word carrying no character shows a zero byte.
  a_nochar: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == clas_pkg::CH_NUL)
    else $error("stray byte on word without character");

  // A produced word is never lost while the far side stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held word dropped");

endmodule
